// File: hw/rtl/switch_event_rule_engine_assert.svh
// Assertion macros shared by the switch event rule engine modules.
`ifndef SWITCH_EVENT_RULE_ENGINE_ASSERT_SVH
`define SWITCH_EVENT_RULE_ENGINE_ASSERT_SVH
// Same-cycle implication, checked out of reset.
`define SERE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sere assertion failed");
// Next-cycle implication, checked out of reset.
`define SERE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sere assertion failed");
`endif

// File: hw/rtl/sere_pkg.sv
// Types, codes and constants of the switch event rule engine.
package sere_pkg;
  localparam int SWITCHES = 16;
  localparam int SW_W = (SWITCHES > 1) ? $clog2(SWITCHES) : 1;
  localparam int CNT_W = 5;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [3:0] OP_LEVEL   = 4'd0;
  localparam logic [3:0] OP_TICK    = 4'd1;
  localparam logic [3:0] OP_ALLST   = 4'd2;
  localparam logic [3:0] OP_STATUS  = 4'd3;
  localparam logic [3:0] OP_GETVAL  = 4'd4;
  localparam logic [3:0] OP_SETPOLL = 4'd5;
  localparam logic [3:0] OP_SETTRIG = 4'd6;
  localparam logic [3:0] OP_SETDEB  = 4'd7;
  localparam logic [3:0] OP_GETRULE = 4'd8;
  localparam logic [3:0] OP_SETRULE = 4'd9;

  localparam logic [1:0] ACT_LEVEL = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_MSG   = 2'd2;

  localparam logic [7:0] FN_STATUS = 8'h00;
  localparam logic [7:0] FN_POLL   = 8'h01;
  localparam logic [7:0] FN_TRIG   = 8'h02;
  localparam logic [7:0] FN_DEB    = 8'h03;
  localparam logic [7:0] FN_OPEN   = 8'h04;
  localparam logic [7:0] FN_CLOSE  = 8'h05;
  localparam logic [7:0] FN_ALLST  = 8'h06;

  localparam logic [1:0] KIND_RESP   = 2'd0;
  localparam logic [1:0] KIND_SOL    = 2'd1;
  localparam logic [1:0] KIND_NOTICE = 2'd2;

  localparam logic [1:0] EDGE_NONE   = 2'd0;
  localparam logic [1:0] EDGE_CLOSED = 2'd1;
  localparam logic [1:0] EDGE_OPENED = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  switch_index;
    logic        switch_level;
    logic [15:0] switch_levels;
    logic [31:0] tick_count;
    logic [7:0]  function_code;
    logic        is_request;
    logic [3:0]  msg_priority;
    logic [3:0]  data_count;
    logic [55:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  out_priority;
    logic [7:0]  target_board;
    logic [7:0]  feature_number;
    logic [2:0]  out_function;
    logic [2:0]  out_length;
    logic [55:0] out_payload;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [3:0]      op;
    logic [SW_W-1:0] sw;
    logic            lvl;
    logic [15:0]     levels;
    logic [31:0]     tick;
    logic [3:0]      prio;
    logic [2:0]      func;
    logic            close;
    logic [7:0]      b0;
    logic [47:0]     rule;
    logic [CNT_W-1:0] cnt;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;
endpackage

// File: hw/rtl/sere_fifo.sv
// Short job queue between the front and the back of the engine.
module sere_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sere_pkg::job_t  push_data_i,
  input  logic            pop_i,
  output sere_pkg::job_t  pop_data_o,
  output sere_pkg::q_stat_t status_o
);
  import sere_pkg::*;
  `include "switch_event_rule_engine_assert.svh"

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign status_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  `SERE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QDEPTH))
  `SERE_ASSERT_NOW(a_no_pop_empty, pop_i, cnt_q != '0)
endmodule

// File: hw/rtl/sere_front.sv
// Front end: accepts input items and the count register, classifies items into jobs.
module sere_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  sere_pkg::in_item_t         in_data_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sere_pkg::CNT_W-1:0] cfg_data_i,
  input  sere_pkg::q_stat_t          q_stat_i,
  output logic                       push_o,
  output sere_pkg::job_t             job_o
);
  import sere_pkg::*;

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] cnt;
  logic             keep;
  logic             in_range;
  logic [7:0]       fn;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_stat_i.full;
  assign cnt         = (count_q > CNT_W'(SWITCHES)) ? CNT_W'(SWITCHES) : count_q;
  assign in_range    = in_data_i.switch_index < {3'b000, cnt};
  assign fn          = in_data_i.function_code;
  assign push_o      = in_valid_i && in_ready_o && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  always_comb begin
    keep          = 1'b0;
    job_o.op      = OP_LEVEL;
    job_o.sw      = in_data_i.switch_index[SW_W-1:0];
    job_o.lvl     = in_data_i.switch_level;
    job_o.levels  = in_data_i.switch_levels;
    job_o.tick    = in_data_i.tick_count;
    job_o.prio    = in_data_i.msg_priority;
    job_o.func    = fn[2:0];
    job_o.close   = (fn == FN_CLOSE);
    job_o.b0      = in_data_i.payload[7:0];
    job_o.rule    = {16'h0000, in_data_i.payload[39:8]};
    job_o.cnt     = cnt;
    if (in_data_i.data_count >= 4'd7) begin
      job_o.rule[47:32] = in_data_i.payload[55:40];
    end
    case (in_data_i.action)
      ACT_LEVEL: begin
        keep     = in_range;
        job_o.op = OP_LEVEL;
      end
      ACT_TICK: begin
        keep     = 1'b1;
        job_o.op = OP_TICK;
      end
      ACT_MSG: begin
        if (fn == FN_ALLST) begin
          keep     = in_data_i.is_request;
          job_o.op = OP_ALLST;
        end else if (fn < FN_ALLST && in_range) begin
          if (fn == FN_STATUS) begin
            keep     = in_data_i.is_request;
            job_o.op = OP_STATUS;
          end else if (fn inside {FN_POLL, FN_TRIG, FN_DEB}) begin
            if (in_data_i.is_request) begin
              keep     = 1'b1;
              job_o.op = OP_GETVAL;
            end else begin
              keep     = in_data_i.data_count != 4'd0;
              job_o.op = (fn == FN_POLL) ? OP_SETPOLL :
                         (fn == FN_TRIG) ? OP_SETTRIG : OP_SETDEB;
            end
          end else begin
            if (in_data_i.is_request) begin
              keep     = 1'b1;
              job_o.op = OP_GETRULE;
            end else begin
              keep     = in_data_i.data_count != 4'd0 &&
                         !(job_o.b0 != 8'd0 && in_data_i.data_count < 4'd5);
              job_o.op = OP_SETRULE;
            end
          end
        end
      end
      default: keep = 1'b0;
    endcase
  end
endmodule

// File: hw/rtl/sere_back.sv
// Back end: holds the switch tables and steps each job, at most one result a step.
module sere_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sere_pkg::q_stat_t   q_stat_i,
  input  sere_pkg::job_t      job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sere_pkg::out_item_t out_data_o
);
  import sere_pkg::*;
  `include "switch_event_rule_engine_assert.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_FIRE = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]          st_q, st_d;
  job_t                job_q;
  logic [CNT_W-1:0]    scan_q, scan_d;
  logic [1:0]          edge_q, edge_d;
  logic                pend_v_q, out_v_q;
  out_item_t           pend_q, out_q, out_d;

  logic [SWITCHES-1:0] lvl_q;
  logic [1:0]          trig_q  [SWITCHES];
  logic [7:0]          poll_q  [SWITCHES];
  logic [31:0]         ptick_q [SWITCHES];
  logic [7:0]          deb_q   [SWITCHES];
  logic [1:0]          ren_q   [SWITCHES];
  logic [47:0]         orule_q [SWITCHES];
  logic [47:0]         crule_q [SWITCHES];

  logic [SW_W-1:0]     idx;
  logic                nlvl, curl, poll_hit, scan_end, fclose, fen, rbit;
  logic [1:0]          edge_c;
  logic [47:0]         frule, rrule;
  logic [15:0]         allbits;
  logic                emit_v, step_ok, mv_ok, load_out;
  out_item_t           emit_r;
  logic [7:0]          getval;

  function automatic out_item_t mk(input logic [1:0] kind, input logic [3:0] prio,
                                   input logic [7:0] board, input logic [7:0] feat,
                                   input logic [2:0] func, input logic [2:0] len,
                                   input logic [55:0] pay);
    out_item_t r;
    r.result_kind    = kind;
    r.out_priority   = prio;
    r.target_board   = board;
    r.feature_number = feat;
    r.out_function   = func;
    r.out_length     = len;
    r.out_payload    = pay;
    r.last           = 1'b0;
    return r;
  endfunction

  assign idx      = (job_q.op == OP_TICK) ? scan_q[SW_W-1:0] : job_q.sw;
  assign curl     = lvl_q[idx];
  assign nlvl     = (job_q.op == OP_LEVEL) ? job_q.lvl : job_q.levels[idx];
  assign edge_c   = (nlvl && !curl) ? EDGE_CLOSED : ((!nlvl && curl) ? EDGE_OPENED : EDGE_NONE);
  assign poll_hit = (poll_q[idx] != 8'd0) &&
                    ((job_q.tick - ptick_q[idx]) >= {24'h000000, poll_q[idx]});
  assign scan_end = scan_q >= job_q.cnt;
  assign fclose   = (edge_q == EDGE_CLOSED);
  assign fen      = fclose ? ren_q[idx][1] : ren_q[idx][0];
  assign frule    = fclose ? crule_q[idx] : orule_q[idx];
  assign rbit     = job_q.close ? ren_q[idx][1] : ren_q[idx][0];
  assign rrule    = job_q.close ? crule_q[idx] : orule_q[idx];
  assign mv_ok    = !out_v_q || out_ready_i;

  always_comb begin
    allbits = '0;
    for (int i = 0; i < SWITCHES; i++) begin
      if (CNT_W'(i) < job_q.cnt) begin
        allbits[i] = job_q.levels[i];
      end
    end
  end

  always_comb begin
    case (job_q.func)
      3'd1:    getval = poll_q[idx];
      3'd2:    getval = {6'b000000, trig_q[idx]};
      default: getval = deb_q[idx];
    endcase
  end

  always_comb begin
    st_d   = st_q;
    scan_d = scan_q;
    edge_d = edge_q;
    emit_v = 1'b0;
    emit_r = mk(KIND_RESP, 4'd1, 8'd0, 8'(idx), 3'd0, 3'd2,
                {46'd0, edge_c, 7'd0, nlvl});
    pop_o  = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o  = 1'b1;
          scan_d = '0;
          st_d   = (job_i.op == OP_TICK) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_EXEC: begin
        st_d   = ST_DONE;
        edge_d = edge_c;
        case (job_q.op)
          OP_LEVEL: begin
            if (edge_c != EDGE_NONE) begin
              st_d   = ST_FIRE;
              emit_v = (edge_c == EDGE_OPENED) ? trig_q[idx][1] : trig_q[idx][0];
            end
          end
          OP_STATUS: begin
            emit_v = 1'b1;
            emit_r.out_priority = job_q.prio;
            if (edge_c != EDGE_NONE) begin
              st_d = ST_FIRE;
            end
          end
          OP_ALLST: begin
            emit_v = 1'b1;
            emit_r = mk(KIND_RESP, job_q.prio, 8'd0, 8'd0, 3'd6, 3'd2, {40'd0, allbits});
          end
          OP_GETVAL: begin
            emit_v = 1'b1;
            emit_r = mk(KIND_RESP, job_q.prio, 8'd0, 8'(idx), job_q.func, 3'd1,
                        {48'd0, getval});
          end
          OP_SETDEB: begin
            emit_v = 1'b1;
            emit_r = mk(KIND_NOTICE, 4'd1, 8'd0, 8'(idx), 3'd3, 3'd1, {48'd0, job_q.b0});
          end
          OP_GETRULE: begin
            emit_v = 1'b1;
            emit_r = mk(KIND_RESP, job_q.prio, 8'd0, 8'(idx), job_q.func, 3'd7,
                        {rrule, 7'd0, rbit});
          end
          OP_SETRULE: begin
            emit_v = rbit;
            emit_r = mk(KIND_SOL, 4'd1, rrule[7:0], rrule[15:8], 3'd0, 3'd1, 56'd0);
          end
          default: emit_v = 1'b0;
        endcase
      end
      ST_SCAN: begin
        edge_d = edge_c;
        if (scan_end) begin
          st_d = ST_DONE;
        end else if (poll_hit) begin
          emit_v = 1'b1;
          if (edge_c != EDGE_NONE) begin
            st_d = ST_FIRE;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_FIRE: begin
        emit_v = fen;
        emit_r = mk(KIND_SOL, 4'd1, frule[7:0], frule[15:8], 3'd0, 3'd4,
                    {24'd0, frule[47:16]});
        if (job_q.op == OP_TICK) begin
          scan_d = scan_q + 1'b1;
          st_d   = ST_SCAN;
        end else begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  assign step_ok = (st_q == ST_DONE) ? (!pend_v_q || mv_ok)
                                     : (!(emit_v && pend_v_q) || mv_ok);
  assign load_out = step_ok && pend_v_q && (emit_v || st_q == ST_DONE);

  always_comb begin
    out_d      = pend_q;
    out_d.last = (st_q == ST_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      scan_q   <= '0;
      edge_q   <= EDGE_NONE;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      lvl_q    <= '0;
      for (int i = 0; i < SWITCHES; i++) begin
        trig_q[i]  <= '0;
        poll_q[i]  <= '0;
        ptick_q[i] <= '0;
        deb_q[i]   <= '0;
        ren_q[i]   <= '0;
        orule_q[i] <= '0;
        crule_q[i] <= '0;
      end
    end else begin
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (step_ok) begin
        st_q   <= st_d;
        scan_q <= scan_d;
        edge_q <= edge_d;
        if (emit_v) begin
          pend_v_q <= 1'b1;
        end
        if (st_q == ST_DONE && pend_v_q) begin
          pend_v_q <= 1'b0;
        end
        if (st_q == ST_EXEC) begin
          case (job_q.op)
            OP_LEVEL, OP_STATUS: lvl_q[idx] <= nlvl;
            OP_ALLST: begin
              for (int i = 0; i < SWITCHES; i++) begin
                if (CNT_W'(i) < job_q.cnt) begin
                  lvl_q[i] <= job_q.levels[i];
                end
              end
            end
            OP_SETPOLL: poll_q[idx] <= job_q.b0;
            OP_SETTRIG: trig_q[idx] <= job_q.b0[1:0];
            OP_SETDEB:  deb_q[idx]  <= job_q.b0;
            OP_SETRULE: begin
              if (job_q.close) begin
                ren_q[idx][1] <= job_q.b0 != 8'd0;
                crule_q[idx]  <= job_q.rule;
              end else begin
                ren_q[idx][0] <= job_q.b0 != 8'd0;
                orule_q[idx]  <= job_q.rule;
              end
            end
            default: lvl_q <= lvl_q;
          endcase
        end
        if (st_q == ST_SCAN && !scan_end && poll_hit) begin
          ptick_q[idx] <= job_q.tick;
          lvl_q[idx]   <= nlvl;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (step_ok && emit_v) begin
      pend_q <= emit_r;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `SERE_ASSERT_NOW(a_idle_no_pend, st_q == ST_IDLE, !pend_v_q)
  `SERE_ASSERT_NOW(a_scan_tick, st_q == ST_SCAN, job_q.op == OP_TICK)
  `SERE_ASSERT_NOW(a_fire_edge, st_q == ST_FIRE, edge_q != EDGE_NONE)
  `SERE_ASSERT_NEXT(a_pop_leaves_idle, pop_o, st_q != ST_IDLE)
endmodule

// File: hw/rtl/switch_event_rule_engine.sv
// Top level of the switch event rule engine: front end, job queue and back end.
//
//   channel  direction  signals                               payload
//   in       input      in_valid_i / in_ready_o               in_data_i (in_item_t)
//   out      output     out_valid_o / out_ready_i             out_data_o (out_item_t)
//   cfg      input      cfg_valid_i / cfg_ready_o             cfg_data_i (switch count)
//
// The front end takes one item per cycle while the two-entry queue has room.
// The back end steps a level report or message through its exec and done states, and through
// the fire state too on an edge; a tick scans each switch in use and fires on each polled edge.
// Reset clears all switch tables at once; no clearing pass is needed.
// A stalled output holds at most one result in the output register and one pending.
module switch_event_rule_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  sere_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output sere_pkg::out_item_t        out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sere_pkg::CNT_W-1:0] cfg_data_i
);
  import sere_pkg::*;

  q_stat_t q_stat;
  logic    push, pop;
  job_t    push_job, pop_job;

  sere_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .job_o       (push_job)
  );

  sere_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .status_o    (q_stat)
  );

  sere_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );
endmodule
